### rtl/rgb2hsv_pkg.sv
// ============================================================================
// rgb2hsv_pkg
// Shared types and constants of the RGB to HSV pixel converter.
// ============================================================================
package rgb2hsv_pkg;

    // Hue scale: 1/64 degree per step
    localparam int HUE_W   = 15;
    localparam int HUE_Q_W = 12;   // hue quotient never exceeds sixty degrees

    localparam logic [HUE_Q_W-1:0] HUE_SIXTY     = 12'd3840;
    localparam logic [HUE_W-1:0]   HUE_FULL      = 15'd23040;
    localparam logic [HUE_W-1:0]   HUE_OFS_RED   = 15'd0;
    localparam logic [HUE_W-1:0]   HUE_OFS_GREEN = 15'd7680;
    localparam logic [HUE_W-1:0]   HUE_OFS_BLUE  = 15'd15360;

    // Hue sector, picked by the largest component (red wins ties, then green)
    typedef logic [1:0] sector_t;
    localparam sector_t SECTOR_RED   = 2'd0;
    localparam sector_t SECTOR_GREEN = 2'd1;
    localparam sector_t SECTOR_BLUE  = 2'd2;

    typedef struct packed {
        sector_t sector;
        logic    neg;       // sector difference is negative
        logic    delta_nz;  // max differs from min
        logic    max_nz;    // pixel is not black
    } hue_flags_t;

endpackage

### rtl/rgb2hsv_front.sv
// ============================================================================
// rgb2hsv_front
// Two pipeline stages: max/min/sector select, then the dividend products.
// ============================================================================
module rgb2hsv_front #(
    parameter int COMPONENT_BITS = 8,
    parameter int STEPS          = 12
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [COMPONENT_BITS-1:0]         red,
    input  logic [COMPONENT_BITS-1:0]         green,
    input  logic [COMPONENT_BITS-1:0]         blue,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [COMPONENT_BITS+STEPS-1:0]   num_hue,
    output logic [COMPONENT_BITS+STEPS-1:0]   num_sat,
    output logic [COMPONENT_BITS-1:0]         den_hue,
    output logic [COMPONENT_BITS-1:0]         den_sat,
    output rgb2hsv_pkg::hue_flags_t           flags,
    output logic [COMPONENT_BITS-1:0]         brightness
);

    localparam int NUM_W = COMPONENT_BITS + STEPS;
    localparam logic [NUM_W-1:0] FULL = NUM_W'((1 << COMPONENT_BITS) - 1);

    logic                        s1_ready;
    logic                        s2_ready;

    logic                        s1_valid_reg;
    logic [COMPONENT_BITS-1:0]   s1_delta_reg;
    logic [COMPONENT_BITS-1:0]   s1_mag_reg;
    logic [COMPONENT_BITS-1:0]   s1_max_reg;
    rgb2hsv_pkg::hue_flags_t     s1_flags_reg;

    logic                        s2_valid_reg;
    logic [NUM_W-1:0]            s2_num_hue_reg;
    logic [NUM_W-1:0]            s2_num_sat_reg;
    logic [COMPONENT_BITS-1:0]   s2_delta_reg;
    logic [COMPONENT_BITS-1:0]   s2_max_reg;
    rgb2hsv_pkg::hue_flags_t     s2_flags_reg;

    logic [COMPONENT_BITS-1:0]   max_next;
    logic [COMPONENT_BITS-1:0]   min_next;
    logic [COMPONENT_BITS-1:0]   op_a;
    logic [COMPONENT_BITS-1:0]   op_b;
    logic [COMPONENT_BITS-1:0]   delta_next;
    logic [COMPONENT_BITS-1:0]   mag_next;
    rgb2hsv_pkg::hue_flags_t     flags_next;

    assign s2_ready = !s2_valid_reg || out_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_ready = s1_ready;

    always_comb
    begin
        max_next = red;
        min_next = red;
        if (green > max_next)
        begin
            max_next = green;
        end
        if (blue > max_next)
        begin
            max_next = blue;
        end
        if (green < min_next)
        begin
            min_next = green;
        end
        if (blue < min_next)
        begin
            min_next = blue;
        end
        delta_next = max_next - min_next;

        if (max_next == red)
        begin
            flags_next.sector = rgb2hsv_pkg::SECTOR_RED;
            op_a = green;
            op_b = blue;
        end
        else if (max_next == green)
        begin
            flags_next.sector = rgb2hsv_pkg::SECTOR_GREEN;
            op_a = blue;
            op_b = red;
        end
        else
        begin
            flags_next.sector = rgb2hsv_pkg::SECTOR_BLUE;
            op_a = red;
            op_b = green;
        end
        flags_next.neg      = (op_a < op_b);
        flags_next.delta_nz = (delta_next != '0);
        flags_next.max_nz   = (max_next != '0);
        mag_next = flags_next.neg ? (op_b - op_a) : (op_a - op_b);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && in_valid)
        begin
            s1_delta_reg <= delta_next;
            s1_mag_reg   <= mag_next;
            s1_max_reg   <= max_next;
            s1_flags_reg <= flags_next;
        end
        if (s2_ready && s1_valid_reg)
        begin
            s2_num_hue_reg <= NUM_W'(s1_mag_reg) * NUM_W'(rgb2hsv_pkg::HUE_SIXTY);
            s2_num_sat_reg <= NUM_W'(s1_delta_reg) * FULL;
            s2_delta_reg   <= s1_delta_reg;
            s2_max_reg     <= s1_max_reg;
            s2_flags_reg   <= s1_flags_reg;
        end
    end

    assign out_valid  = s2_valid_reg;
    assign num_hue    = s2_num_hue_reg;
    assign num_sat    = s2_num_sat_reg;
    assign den_hue    = s2_delta_reg;
    assign den_sat    = s2_max_reg;
    assign flags      = s2_flags_reg;
    assign brightness = s2_max_reg;

endmodule

### rtl/rgb2hsv_divider.sv
// ============================================================================
// rgb2hsv_divider
// Pipelined restoring divider, two lanes in lockstep, one quotient bit
// per stage.
// ============================================================================
module rgb2hsv_divider #(
    parameter int COMPONENT_BITS = 8,
    parameter int STEPS          = 12
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [COMPONENT_BITS+STEPS-1:0]   num_hue,
    input  logic [COMPONENT_BITS+STEPS-1:0]   num_sat,
    input  logic [COMPONENT_BITS-1:0]         den_hue,
    input  logic [COMPONENT_BITS-1:0]         den_sat,
    input  rgb2hsv_pkg::hue_flags_t           in_flags,
    input  logic [COMPONENT_BITS-1:0]         in_brightness,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [STEPS-1:0]                  quo_hue,
    output logic                              rem_nz_hue,
    output logic [STEPS-1:0]                  quo_sat,
    output rgb2hsv_pkg::hue_flags_t           out_flags,
    output logic [COMPONENT_BITS-1:0]         out_brightness
);

    localparam int LANES = 2;

    // Index 0 is the input side, index k+1 is the register of stage k
    logic                          src_valid [0:STEPS];
    logic [COMPONENT_BITS-1:0]     src_rem   [0:STEPS][0:LANES-1];
    logic [STEPS-1:0]              src_sh    [0:STEPS][0:LANES-1];
    logic [COMPONENT_BITS-1:0]     src_den   [0:STEPS][0:LANES-1];
    rgb2hsv_pkg::hue_flags_t       src_flags [0:STEPS];
    logic [COMPONENT_BITS-1:0]     src_bright[0:STEPS];
    logic                          rdy       [0:STEPS];

    assign src_valid[0]    = in_valid;
    assign src_rem[0][0]   = num_hue[COMPONENT_BITS+STEPS-1:STEPS];
    assign src_sh[0][0]    = num_hue[STEPS-1:0];
    assign src_den[0][0]   = den_hue;
    assign src_rem[0][1]   = num_sat[COMPONENT_BITS+STEPS-1:STEPS];
    assign src_sh[0][1]    = num_sat[STEPS-1:0];
    assign src_den[0][1]   = den_sat;
    assign src_flags[0]    = in_flags;
    assign src_bright[0]   = in_brightness;
    assign rdy[STEPS]      = out_ready;
    assign in_ready        = rdy[0];

    for (genvar k = 0; k < STEPS; k++)
    begin : g_stage
        logic                        valid_reg;
        logic [COMPONENT_BITS-1:0]   rem_reg   [0:LANES-1];
        logic [STEPS-1:0]            sh_reg    [0:LANES-1];
        logic [COMPONENT_BITS-1:0]   den_reg   [0:LANES-1];
        logic [COMPONENT_BITS-1:0]   rem_next  [0:LANES-1];
        logic [STEPS-1:0]            sh_next   [0:LANES-1];
        rgb2hsv_pkg::hue_flags_t     flags_reg;
        logic [COMPONENT_BITS-1:0]   bright_reg;

        assign rdy[k] = !valid_reg || rdy[k+1];

        for (genvar l = 0; l < LANES; l++)
        begin : g_lane
            logic [COMPONENT_BITS:0] trial;
            logic [COMPONENT_BITS:0] diff;
            logic                    ge;

            always_comb
            begin
                trial = {src_rem[k][l], src_sh[k][l][STEPS-1]};
                diff  = trial - {1'b0, src_den[k][l]};
                ge    = (trial >= {1'b0, src_den[k][l]});
                rem_next[l] = ge ? diff[COMPONENT_BITS-1:0] : trial[COMPONENT_BITS-1:0];
                sh_next[l]  = {src_sh[k][l][STEPS-2:0], ge};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg <= 1'b0;
            end
            else if (rdy[k])
            begin
                valid_reg <= src_valid[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (rdy[k] && src_valid[k])
            begin
                for (int l = 0; l < LANES; l++)
                begin
                    rem_reg[l] <= rem_next[l];
                    sh_reg[l]  <= sh_next[l];
                    den_reg[l] <= src_den[k][l];
                end
                flags_reg  <= src_flags[k];
                bright_reg <= src_bright[k];
            end
        end

        assign src_valid[k+1]  = valid_reg;
        assign src_flags[k+1]  = flags_reg;
        assign src_bright[k+1] = bright_reg;
        for (genvar l = 0; l < LANES; l++)
        begin : g_out
            assign src_rem[k+1][l] = rem_reg[l];
            assign src_sh[k+1][l]  = sh_reg[l];
            assign src_den[k+1][l] = den_reg[l];
        end
    end

    assign out_valid      = src_valid[STEPS];
    assign quo_hue        = src_sh[STEPS][0];
    assign rem_nz_hue     = (src_rem[STEPS][0] != '0);
    assign quo_sat        = src_sh[STEPS][1];
    assign out_flags      = src_flags[STEPS];
    assign out_brightness = src_bright[STEPS];

endmodule

### rtl/rgb2hsv_back.sv
// ============================================================================
// rgb2hsv_back
// Hue sector offset and wrap, saturation select, output register.
// ============================================================================
module rgb2hsv_back #(
    parameter int COMPONENT_BITS = 8,
    parameter int STEPS          = 12
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [STEPS-1:0]                   quo_hue,
    input  logic                               rem_nz_hue,
    input  logic [STEPS-1:0]                   quo_sat,
    input  rgb2hsv_pkg::hue_flags_t            flags,
    input  logic [COMPONENT_BITS-1:0]          in_brightness,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [rgb2hsv_pkg::HUE_W-1:0]      hue,
    output logic [COMPONENT_BITS-1:0]          saturation,
    output logic [COMPONENT_BITS-1:0]          brightness
);

    localparam int HW = rgb2hsv_pkg::HUE_W;
    localparam int QW = rgb2hsv_pkg::HUE_Q_W;

    logic                        valid_reg;
    logic [HW-1:0]               hue_reg;
    logic [COMPONENT_BITS-1:0]   sat_reg;
    logic [COMPONENT_BITS-1:0]   bright_reg;

    logic [HW-1:0]               offset;
    logic [HW-1:0]               up;
    logic [HW-1:0]               hue_next;
    logic [COMPONENT_BITS-1:0]   sat_next;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        case (flags.sector)
            rgb2hsv_pkg::SECTOR_RED:   offset = rgb2hsv_pkg::HUE_OFS_RED;
            rgb2hsv_pkg::SECTOR_GREEN: offset = rgb2hsv_pkg::HUE_OFS_GREEN;
            rgb2hsv_pkg::SECTOR_BLUE:  offset = rgb2hsv_pkg::HUE_OFS_BLUE;
            default:                   offset = rgb2hsv_pkg::HUE_OFS_RED;
        endcase

        // Negative difference: subtract the ceiling of the quotient
        up = HW'(quo_hue[QW-1:0]) + HW'(rem_nz_hue);

        if (!flags.delta_nz)
        begin
            hue_next = '0;
        end
        else if (!flags.neg)
        begin
            hue_next = offset + HW'(quo_hue[QW-1:0]);
        end
        else if (flags.sector == rgb2hsv_pkg::SECTOR_RED)
        begin
            hue_next = rgb2hsv_pkg::HUE_FULL - up;
        end
        else
        begin
            hue_next = offset - up;
        end

        sat_next = flags.max_nz ? quo_sat[COMPONENT_BITS-1:0] : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            hue_reg    <= hue_next;
            sat_reg    <= sat_next;
            bright_reg <= in_brightness;
        end
    end

    assign out_valid  = valid_reg;
    assign hue        = hue_reg;
    assign saturation = sat_reg;
    assign brightness = bright_reg;

endmodule

### rtl/rgb_to_hsv_converter_top.sv
// ============================================================================
// rgb_to_hsv_converter_top
// RGB to HSV pixel converter, one pixel per clock unless the receiver stalls.
// ============================================================================
// Usage:
//   Pixels enter on the s_ stream (red, green, blue) and leave on the m_
//   stream (hue in 1/64 degree, saturation, brightness). A transfer happens
//   on a rising edge with tvalid and tready both high.
//   From input transfer to m_tvalid a pixel passes two front stages
//   (min/max and sector, then dividend products), one divider stage per
//   quotient bit, and the output register. The divider pipeline, one
//   restoring step per stage, makes up most of the pipeline depth.
//   Throughput is one pixel per cycle while m_tready stays high; every stage
//   holds its own valid bit, so empty stages fill while the output waits.
//   When the receiver drops m_tready, the pipeline keeps filling until all
//   stages hold a pixel; then s_tready falls. No pixel is lost or repeated.
//   Reset clears all valid bits; s_tready is high from reset on, so the
//   block accepts pixels as soon as rst_n rises.
// ============================================================================
module rgb_to_hsv_converter_top #(
    parameter int COMPONENT_BITS = 8
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [((3*COMPONENT_BITS+7)/8)*8-1:0] s_tdata,   // red, green, blue
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [((rgb2hsv_pkg::HUE_W+2*COMPONENT_BITS+7)/8)*8-1:0] m_tdata
                                                    // hue, saturation, brightness
);

    localparam int STEPS  = (COMPONENT_BITS > rgb2hsv_pkg::HUE_Q_W)
                            ? COMPONENT_BITS : rgb2hsv_pkg::HUE_Q_W;
    localparam int NUM_W  = COMPONENT_BITS + STEPS;
    localparam int OUT_W  = ((rgb2hsv_pkg::HUE_W + 2*COMPONENT_BITS + 7) / 8) * 8;

    logic                              fr_valid;
    logic                              fr_ready;
    logic [NUM_W-1:0]                  fr_num_hue;
    logic [NUM_W-1:0]                  fr_num_sat;
    logic [COMPONENT_BITS-1:0]         fr_den_hue;
    logic [COMPONENT_BITS-1:0]         fr_den_sat;
    rgb2hsv_pkg::hue_flags_t           fr_flags;
    logic [COMPONENT_BITS-1:0]         fr_bright;

    logic                              dv_valid;
    logic                              dv_ready;
    logic [STEPS-1:0]                  dv_quo_hue;
    logic                              dv_rem_nz_hue;
    logic [STEPS-1:0]                  dv_quo_sat;
    rgb2hsv_pkg::hue_flags_t           dv_flags;
    logic [COMPONENT_BITS-1:0]         dv_bright;

    logic [rgb2hsv_pkg::HUE_W-1:0]     hue;
    logic [COMPONENT_BITS-1:0]         saturation;
    logic [COMPONENT_BITS-1:0]         brightness;

    rgb2hsv_front #(
        .COMPONENT_BITS (COMPONENT_BITS),
        .STEPS          (STEPS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .red        (s_tdata[COMPONENT_BITS-1:0]),
        .green      (s_tdata[2*COMPONENT_BITS-1:COMPONENT_BITS]),
        .blue       (s_tdata[3*COMPONENT_BITS-1:2*COMPONENT_BITS]),
        .out_valid  (fr_valid),
        .out_ready  (fr_ready),
        .num_hue    (fr_num_hue),
        .num_sat    (fr_num_sat),
        .den_hue    (fr_den_hue),
        .den_sat    (fr_den_sat),
        .flags      (fr_flags),
        .brightness (fr_bright)
    );

    rgb2hsv_divider #(
        .COMPONENT_BITS (COMPONENT_BITS),
        .STEPS          (STEPS)
    ) u_divider (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (fr_valid),
        .in_ready       (fr_ready),
        .num_hue        (fr_num_hue),
        .num_sat        (fr_num_sat),
        .den_hue        (fr_den_hue),
        .den_sat        (fr_den_sat),
        .in_flags       (fr_flags),
        .in_brightness  (fr_bright),
        .out_valid      (dv_valid),
        .out_ready      (dv_ready),
        .quo_hue        (dv_quo_hue),
        .rem_nz_hue     (dv_rem_nz_hue),
        .quo_sat        (dv_quo_sat),
        .out_flags      (dv_flags),
        .out_brightness (dv_bright)
    );

    rgb2hsv_back #(
        .COMPONENT_BITS (COMPONENT_BITS),
        .STEPS          (STEPS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (dv_valid),
        .in_ready      (dv_ready),
        .quo_hue       (dv_quo_hue),
        .rem_nz_hue    (dv_rem_nz_hue),
        .quo_sat       (dv_quo_sat),
        .flags         (dv_flags),
        .in_brightness (dv_bright),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .hue           (hue),
        .saturation    (saturation),
        .brightness    (brightness)
    );

    assign m_tdata = OUT_W'({brightness, saturation, hue});

endmodule

### bench/rgb_to_hsv_converter_checker.sv
`timescale 1ns / 100ps
// ============================================================================
// rgb_to_hsv_converter_checker
// Watches both pixel streams of the converter, computes the expected hue,
// saturation and brightness of every pixel taken in, and compares them in
// order with the pixels that leave. Hands the mismatch count and the number
// of pixels still owed to the testbench top.
// ============================================================================
module rgb_to_hsv_converter_checker #(
    parameter int COMPONENT_BITS = 8
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_tvalid,
    input  logic                    s_tready,
    input  logic [((3*COMPONENT_BITS+7)/8)*8-1:0] s_tdata,   // red, green, blue
    input  logic                    m_tvalid,
    input  logic                    m_tready,
    input  logic [((rgb2hsv_pkg::HUE_W+2*COMPONENT_BITS+7)/8)*8-1:0] m_tdata,
                                                    // hue, saturation, brightness
    output int                      mismatch_count,
    output int                      pending_count
);

    localparam int HUE_W           = rgb2hsv_pkg::HUE_W;
    localparam int HUE_SIXTY_STEPS = 3840;
    localparam int HUE_TURN        = 23040;
    localparam int FULL_SCALE      = (1 << COMPONENT_BITS) - 1;
    localparam int REPORT_LIMIT    = 10;

    typedef struct packed {
        logic [HUE_W-1:0]          hue;
        logic [COMPONENT_BITS-1:0] saturation;
        logic [COMPONENT_BITS-1:0] brightness;
    } hsv_pixel_t;

    hsv_pixel_t hsv_expect_q[$];

    // Exact integer HSV with floor rounding; red wins ties, then green
    function automatic hsv_pixel_t predict_hsv(input int red, input int green,
                                               input int blue);
        hsv_pixel_t px;
        int top;
        int bottom;
        int delta;
        int offset;
        int diff;
        int num;
        int quot;
        int angle;
        top    = red;
        bottom = red;
        if (green > top) top = green;
        if (blue > top) top = blue;
        if (green < bottom) bottom = green;
        if (blue < bottom) bottom = blue;
        delta = top - bottom;
        angle = 0;
        if (delta != 0)
        begin
            if (top == red)
            begin
                offset = 0;
                diff   = green - blue;
            end
            else if (top == green)
            begin
                offset = 2 * HUE_SIXTY_STEPS;
                diff   = blue - red;
            end
            else
            begin
                offset = 4 * HUE_SIXTY_STEPS;
                diff   = red - green;
            end
            num  = HUE_SIXTY_STEPS * diff;
            quot = num / delta;
            // division truncates toward zero; push negative quotients down
            if (num < 0 && quot * delta != num)
                quot = quot - 1;
            angle = offset + quot;
            if (angle < 0)
                angle = angle + HUE_TURN;
            else if (angle >= HUE_TURN)
                angle = angle - HUE_TURN;
        end
        px.hue        = angle[HUE_W-1:0];
        px.saturation = (top == 0) ? '0 : COMPONENT_BITS'((FULL_SCALE * delta) / top);
        px.brightness = COMPONENT_BITS'(top);
        return px;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        hsv_pixel_t got;
        hsv_pixel_t want;
        if (!rst_n)
        begin
            hsv_expect_q.delete();
            mismatch_count <= 0;
            pending_count  <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got.hue        = m_tdata[HUE_W-1:0];
                got.saturation = m_tdata[HUE_W +: COMPONENT_BITS];
                got.brightness = m_tdata[HUE_W+COMPONENT_BITS +: COMPONENT_BITS];
                if (hsv_expect_q.size() == 0)
                begin
                    mismatch_count <= mismatch_count + 1;
                    if (mismatch_count < REPORT_LIMIT)
                        $display("%0t: unexpected pixel out: hue %0d sat %0d val %0d",
                                 $realtime, got.hue, got.saturation, got.brightness);
                end
                else
                begin
                    want = hsv_expect_q.pop_front();
                    if (got.hue !== want.hue || got.saturation !== want.saturation ||
                        got.brightness !== want.brightness)
                    begin
                        mismatch_count <= mismatch_count + 1;
                        if (mismatch_count < REPORT_LIMIT)
                            $display({"%0t: pixel mismatch: expected hue %0d sat %0d",
                                      " val %0d, got hue %0d sat %0d val %0d"},
                                     $realtime, want.hue, want.saturation,
                                     want.brightness, got.hue, got.saturation,
                                     got.brightness);
                    end
                end
            end
            if (s_tvalid && s_tready)
                hsv_expect_q.push_back(predict_hsv(
                    int'(s_tdata[0 +: COMPONENT_BITS]),
                    int'(s_tdata[COMPONENT_BITS +: COMPONENT_BITS]),
                    int'(s_tdata[2*COMPONENT_BITS +: COMPONENT_BITS])));
            pending_count <= hsv_expect_q.size();
        end
    end

endmodule

### bench/rgb_to_hsv_converter_top_tb.sv
`timescale 1ns / 100ps
// ============================================================================
// rgb_to_hsv_converter_top_tb
// Drives pixels into the RGB to HSV converter: a directed set of corner
// colors, then random pixels weighted toward gray, tied, saturated and dark
// colors, with random gaps and receiver stalls. The checker module does the
// comparison; this top gives the verdict.
// ============================================================================
module rgb_to_hsv_converter_top_tb;

    localparam int COMPONENT_BITS = 8;
    localparam int RANDOM_PIXELS  = 1650;
    localparam int CYCLE_LIMIT    = 300000;
    localparam int DRAIN_CYCLES   = 30;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;    // red, green, blue
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;    // hue, saturation, brightness

    logic        free_run;
    int          stall_left;
    int          cycle_count = 0;
    int          mismatch_count;
    int          pending_count;

    rgb_to_hsv_converter_top #(
        .COMPONENT_BITS(COMPONENT_BITS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata)
    );

    rgb_to_hsv_converter_checker #(
        .COMPONENT_BITS(COMPONENT_BITS)
    ) checker_i (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .mismatch_count(mismatch_count),
        .pending_count(pending_count)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    initial
    begin
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        free_run = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Receiver: random stalls, now and then a long one to back up the pipeline
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready   <= 1'b0;
            stall_left <= 0;
        end
        else if (free_run)
            m_tready <= 1'b1;
        else if (stall_left != 0)
        begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if ($urandom_range(299) == 0)
        begin
            m_tready   <= 1'b0;
            stall_left <= $urandom_range(40, 20);
        end
        else
            m_tready <= ($urandom_range(99) >= 29);
    end

    // Hold the pixel until the transfer; valid stays high between pixels unless a random gap drops it
    task automatic send_pixel(input logic [7:0] red, input logic [7:0] green,
                              input logic [7:0] blue);
        while (!free_run && $urandom_range(99) < 29)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {blue, green, red};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    initial
    begin
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] base;
        @(posedge rst_n);
        @(posedge clk);

        // black, white, gray
        send_pixel(8'd0, 8'd0, 8'd0);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd128, 8'd128, 8'd128);
        send_pixel(8'd1, 8'd1, 8'd1);
        // primaries and secondaries, ties resolved red then green
        send_pixel(8'd255, 8'd0, 8'd0);
        send_pixel(8'd0, 8'd255, 8'd0);
        send_pixel(8'd0, 8'd0, 8'd255);
        send_pixel(8'd255, 8'd255, 8'd0);
        send_pixel(8'd0, 8'd255, 8'd255);
        send_pixel(8'd255, 8'd0, 8'd255);
        // red sector going negative, wrap near the top of the range
        send_pixel(8'd255, 8'd0, 8'd1);
        send_pixel(8'd255, 8'd0, 8'd254);
        send_pixel(8'd2, 8'd0, 8'd1);
        send_pixel(8'd255, 8'd1, 8'd0);
        // smallest nonzero delta in every sector, then two mixed colors
        send_pixel(8'd1, 8'd0, 8'd0);
        send_pixel(8'd0, 8'd1, 8'd0);
        send_pixel(8'd0, 8'd0, 8'd1);
        send_pixel(8'd255, 8'd254, 8'd254);
        send_pixel(8'd254, 8'd255, 8'd254);
        send_pixel(8'd254, 8'd254, 8'd255);
        send_pixel(8'd170, 8'd85, 8'd255);
        send_pixel(8'd85, 8'd255, 8'd170);

        for (int i = 0; i < RANDOM_PIXELS; i++)
        begin
            free_run <= (i >= 700 && i < 1000);
            red   = 8'($urandom_range(255));
            green = 8'($urandom_range(255));
            blue  = 8'($urandom_range(255));
            case ($urandom_range(9))
                0:
                begin
                    // near gray: tiny delta, large hue steps
                    base  = 8'($urandom_range(255));
                    red   = base ^ 8'($urandom_range(3));
                    green = base ^ 8'($urandom_range(3));
                    blue  = base ^ 8'($urandom_range(3));
                end
                1:
                begin
                    // two components tied
                    case ($urandom_range(2))
                        0: green = red;
                        1: blue = red;
                        default: blue = green;
                    endcase
                end
                2:
                begin
                    // components at the rails
                    if ($urandom_range(1) == 0) red = ($urandom_range(1) == 0) ? 8'd0 : 8'd255;
                    if ($urandom_range(1) == 0) green = ($urandom_range(1) == 0) ? 8'd0 : 8'd255;
                    if ($urandom_range(1) == 0) blue = ($urandom_range(1) == 0) ? 8'd0 : 8'd255;
                end
                3:
                begin
                    // dark pixels
                    red   = 8'($urandom_range(3));
                    green = 8'($urandom_range(3));
                    blue  = 8'($urandom_range(3));
                end
                default:
                begin
                end
            endcase
            send_pixel(red, green, blue);
        end

        free_run <= 1'b0;
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

### sim.f
rtl/rgb2hsv_pkg.sv
rtl/rgb2hsv_front.sv
rtl/rgb2hsv_divider.sv
rtl/rgb2hsv_back.sv
rtl/rgb_to_hsv_converter_top.sv
bench/rgb_to_hsv_converter_checker.sv
bench/rgb_to_hsv_converter_top_tb.sv
